### rtl/mh2a_pkg.sv
package mh2a_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_H,
        ST_FIN
    } state_t;

    // which mix the sequencer is running
    typedef enum logic [1:0] {
        MIX_WORD,
        MIX_TAIL,
        MIX_LEN
    } mix_t;

    // operand selection for the shared multiplier
    typedef enum logic [1:0] {
        MUL_K,      // k * M
        MUL_KS,     // (k ^ k >> 24) * M
        MUL_H,      // h * M
        MUL_HF      // (h ^ h >> 13) * M
    } mul_op_t;

endpackage

### rtl/mh2a_mul_unit.sv
module mh2a_mul_unit
(
    input  mh2a_pkg::mul_op_t op,
    input  logic [31:0]       k,
    input  logic [31:0]       h,
    output logic [31:0]       product
);

    logic [31:0] operand;

    always_comb
    begin
        case (op)
            mh2a_pkg::MUL_K:  operand = k;
            mh2a_pkg::MUL_KS: operand = k ^ (k >> mh2a_pkg::MIX_SHIFT);
            mh2a_pkg::MUL_H:  operand = h;
            mh2a_pkg::MUL_HF: operand = h ^ (h >> mh2a_pkg::FIN_SHIFT_A);
            default:          operand = k;
        endcase
    end

    // only the low word of the product is kept
    assign product = operand * mh2a_pkg::MIX_MUL;

endmodule

### rtl/murmur2a_hash32_stream.sv
// Channel  Dir  Signals                       Contents
// s_*      in   tvalid tready tdata tuser tlast  tdata: data_byte; tuser: byte_present;
//                                                tlast: last_byte
// m_*      out  tvalid tready tdata              tdata: hash_value
//
// A byte that does not complete a word is stored in the partial word; one that
// completes a word is accepted and then mixed by three multiplies. A last request
// adds the tail, length and final mixes. One 32x32 multiplier, used once per
// cycle, does every multiply. rst_n at once clears all state but k_reg and out_data_reg.
// The result sits in an output register; a stalled output holds the final
// step only: the next message is taken in and mixed up to its final step.
module murmur2a_hash32_stream
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash_value
);

    mh2a_pkg::state_t  state_reg, state_next;
    mh2a_pkg::mix_t    stage_reg, stage_next;
    mh2a_pkg::mul_op_t mul_op;

    logic [31:0] hash_reg, hash_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] length_reg, length_next;
    logic [23:0] partial_reg, partial_next;
    logic [1:0]  phase_reg, phase_next;
    logic        fin_pend_reg, fin_pend_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    logic [31:0] product;
    logic [23:0] partial_ins;
    logic        s_acc;

    mh2a_mul_unit u_mul
    (
        .op      (mul_op),
        .k       (k_reg),
        .h       (hash_reg),
        .product (product)
    );

    assign s_tready    = (state_reg == mh2a_pkg::ST_IDLE);
    assign s_acc       = s_tvalid && s_tready;
    assign partial_ins = partial_reg | ({16'b0, s_tdata} << {phase_reg, 3'b000});
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mh2a_pkg::ST_IDLE;
            stage_reg     <= mh2a_pkg::MIX_WORD;
            hash_reg      <= '0;
            length_reg    <= '0;
            partial_reg   <= '0;
            phase_reg     <= '0;
            fin_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            hash_reg      <= hash_next;
            length_reg    <= length_next;
            partial_reg   <= partial_next;
            phase_reg     <= phase_next;
            fin_pend_reg  <= fin_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        stage_next     = stage_reg;
        hash_next      = hash_reg;
        k_next         = k_reg;
        length_next    = length_reg;
        partial_next   = partial_reg;
        phase_next     = phase_reg;
        fin_pend_next  = fin_pend_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        mul_op         = mh2a_pkg::MUL_K;

        case (state_reg)
            mh2a_pkg::ST_IDLE:
            begin
                if (s_acc)
                begin
                    if (s_tuser)
                    begin
                        length_next = length_reg + 32'd1;
                        if (phase_reg == 2'd3)
                        begin
                            k_next        = {s_tdata, partial_reg};
                            partial_next  = '0;
                            phase_next    = '0;
                            stage_next    = mh2a_pkg::MIX_WORD;
                            fin_pend_next = s_tlast;
                            state_next    = mh2a_pkg::ST_K1;
                        end
                        else
                        begin
                            partial_next = partial_ins;
                            phase_next   = phase_reg + 2'd1;
                            if (s_tlast)
                            begin
                                k_next     = {8'b0, partial_ins};
                                stage_next = mh2a_pkg::MIX_TAIL;
                                state_next = mh2a_pkg::ST_K1;
                            end
                        end
                    end
                    else if (s_tlast)
                    begin
                        k_next     = {8'b0, partial_reg};
                        stage_next = mh2a_pkg::MIX_TAIL;
                        state_next = mh2a_pkg::ST_K1;
                    end
                end
            end
            mh2a_pkg::ST_K1:
            begin
                mul_op     = mh2a_pkg::MUL_K;
                k_next     = product;
                state_next = mh2a_pkg::ST_K2;
            end
            mh2a_pkg::ST_K2:
            begin
                mul_op     = mh2a_pkg::MUL_KS;
                k_next     = product;
                state_next = mh2a_pkg::ST_H;
            end
            mh2a_pkg::ST_H:
            begin
                mul_op    = mh2a_pkg::MUL_H;
                hash_next = product ^ k_reg;
                case (stage_reg)
                    mh2a_pkg::MIX_WORD:
                    begin
                        if (fin_pend_reg)
                        begin
                            // word just completed, so the tail is empty
                            k_next     = {8'b0, partial_reg};
                            stage_next = mh2a_pkg::MIX_TAIL;
                            state_next = mh2a_pkg::ST_K1;
                        end
                        else
                        begin
                            state_next = mh2a_pkg::ST_IDLE;
                        end
                    end
                    mh2a_pkg::MIX_TAIL:
                    begin
                        k_next     = length_reg;
                        stage_next = mh2a_pkg::MIX_LEN;
                        state_next = mh2a_pkg::ST_K1;
                    end
                    default:
                    begin
                        state_next = mh2a_pkg::ST_FIN;
                    end
                endcase
            end
            mh2a_pkg::ST_FIN:
            begin
                mul_op = mh2a_pkg::MUL_HF;
                // wait here while an earlier hash is still on offer
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = product ^ (product >> mh2a_pkg::FIN_SHIFT_B);
                    out_valid_next = 1'b1;
                    hash_next      = '0;
                    length_next    = '0;
                    partial_next   = '0;
                    phase_next     = '0;
                    fin_pend_next  = 1'b0;
                    stage_next     = mh2a_pkg::MIX_WORD;
                    state_next     = mh2a_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mh2a_pkg::ST_IDLE;
            end
        endcase
    end

    // bytes above the current phase are always clear; checked here at phase zero
    a_partial_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == 2'd0) |-> (partial_reg == 24'd0))
        else $error("partial word not clear at phase zero");

    // a last request without a word to mix goes straight to the tail mix
    a_last_to_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_tlast && !(s_tuser && (phase_reg == 2'd3)))
        |=> (state_reg == mh2a_pkg::ST_K1) && (stage_reg == mh2a_pkg::MIX_TAIL))
        else $error("last request did not start tail mix");

    // a result only appears out of the final step
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == mh2a_pkg::ST_FIN))
        else $error("result raised outside the final step");

    // the final step never overwrites a hash still on offer
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> $stable(out_data_reg))
        else $error("pending hash overwritten");

endmodule
